FILE: sv/qrs_pkg.sv
// Shared types for the quadratic root solver: result status codes.
package qrs_pkg;

	typedef enum logic [1:0] {
		ST_TWO_ROOTS   = 2'd0,
		ST_DOUBLE_ROOT = 2'd1,
		ST_NO_REAL     = 2'd2,
		ST_NOT_QUAD    = 2'd3
	} qrs_status_t;

endpackage

FILE: sv/quadratic_root_solver.sv
// Quadratic root solver top level: discriminant, pipelined square root and dividers.
//
//  channel   | dir | tdata (low bit first)                           | tuser
//  ----------+-----+-------------------------------------------------+--------
//  s_axis    | in  | coeff_a, coeff_b, coeff_c                       | -
//  m_axis    | out | root_one, root_two, vertex_x, vertex_y          | status
//
// One beat in per cycle while m_axis is not stalled, one beat out per beat in.
// The pipe holds one stage per root bit in the square root and one stage per
// quotient bit in the four dividers, plus the S1 to S5 and output registers.
// arst_n clears only the valid bits; payload registers carry no reset.
// All stages move together; a stall on m_axis holds the whole pipe and
// drops s_axis_tready in the same cycle, so nothing is lost or repeated.
module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int COEFF_WIDTH = 16,
	parameter int FRAC_BITS   = 16,
	localparam int ROOT_W = COEFF_WIDTH + FRAC_BITS + 3,
	localparam int VY_W   = 2 * COEFF_WIDTH + FRAC_BITS - 2,
	localparam int IN_W   = ((3 * COEFF_WIDTH + 7) / 8) * 8,
	localparam int OUT_W  = ((3 * ROOT_W + VY_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // coeff_a, coeff_b, coeff_c, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // root_one, root_two, vertex_x, vertex_y, zero pad
	output logic [1:0]       m_axis_tuser    // status
);

	localparam int CW    = COEFF_WIDTH;
	localparam int DW    = 2 * CW + 3;                  // discriminant, signed
	localparam int RW    = (DW + 2 * FRAC_BITS + 2) / 2; // square root bits
	localparam int EW    = 2 * RW;                       // radicand bits
	localparam int SH    = 2 * FRAC_BITS + 2;
	localparam int REM_W = RW + 3;
	localparam int DIV_W = DW + FRAC_BITS + 1;           // dividend / quotient
	localparam int SW    = DIV_W + 1;                    // signed working width
	localparam int DEN_W = CW + 3;
	localparam int XW    = CW + FRAC_BITS + 2;           // 2*(-b*sgn a)*2^F
	localparam int AW    = CW + 1;

	typedef struct packed {
		qrs_status_t      status;
		logic             a_neg;
		logic [AW-1:0]    a_abs;
		logic [XW-1:0]    x;
		logic [DIV_W-1:0] vx_num;
		logic             vx_neg;
		logic [DIV_W-1:0] vy_num;
		logic             vy_neg;
	} side_t;

	typedef struct packed {
		qrs_status_t status;
		logic        r1_neg;
		logic        r2_neg;
		logic        vx_neg;
		logic        vy_neg;
	} dside_t;

	logic adv;
	logic m_valid_q;

	// whole pipe advances when the output register is free or being drained
	assign adv           = ~m_valid_q | m_axis_tready;
	assign s_axis_tready = adv;

	// ---- S1: products ----
	logic signed [CW-1:0]   in_a, in_b, in_c;
	logic                   v_s1;
	logic signed [2*CW-1:0] bb_s1, ac_s1;
	logic signed [CW-1:0]   a_s1, b_s1;

	assign in_a = s_axis_tdata[CW-1:0];
	assign in_b = s_axis_tdata[2*CW-1:CW];
	assign in_c = s_axis_tdata[3*CW-1:2*CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s1 <= in_b * in_b;
			ac_s1 <= in_a * in_c;
			a_s1  <= in_a;
			b_s1  <= in_b;
		end
	end

	// ---- S2: discriminant ----
	logic                 v_s2;
	logic signed [DW-1:0] d_s2;
	logic signed [CW-1:0] a_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2 <= DW'(bb_s1) - (DW'(ac_s1) <<< 2);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	// ---- S3: classify, magnitudes, radicand, vertex dividends ----
	logic                 a_neg, b_neg, d_neg;
	logic signed [AW-1:0] a_ext, b_ext;
	logic [AW-1:0]        a_abs, b_abs;
	logic [DW-1:0]        d_abs;
	logic signed [XW-1:0] b_wide, x_root;
	qrs_status_t          status_c;
	side_t                side_c;
	logic [EW-1:0]        rad_c;

	assign a_neg  = a_s2[CW-1];
	assign b_neg  = b_s2[CW-1];
	assign d_neg  = d_s2[DW-1];
	assign a_ext  = AW'(a_s2);
	assign b_ext  = AW'(b_s2);
	assign a_abs  = a_neg ? -a_ext : a_ext;
	assign b_abs  = b_neg ? -b_ext : b_ext;
	assign d_abs  = d_neg ? -d_s2 : d_s2;
	assign b_wide = XW'(b_s2);
	assign x_root = (a_neg ? b_wide : -b_wide) <<< (FRAC_BITS + 1);

	always_comb begin
		priority if (a_s2 == '0) begin
			status_c = ST_NOT_QUAD;
		end else if (d_neg) begin
			status_c = ST_NO_REAL;
		end else if (d_s2 == '0) begin
			status_c = ST_DOUBLE_ROOT;
		end else begin
			status_c = ST_TWO_ROOTS;
		end
	end

	// negative radicand never reaches the roots; feed zero
	assign rad_c = d_neg ? '0 : (EW'(d_s2[DW-2:0]) << SH);

	always_comb begin
		side_c.status = status_c;
		side_c.a_neg  = a_neg;
		side_c.a_abs  = a_abs;
		side_c.x      = x_root;
		// vertex x: (|b|*2^(F+1) + |2a|) / |4a|, sign from -b*sgn(a)
		side_c.vx_num = (DIV_W'(b_abs) << (FRAC_BITS + 1)) + (DIV_W'(a_abs) << 1);
		side_c.vx_neg = (b_s2 != '0) && (b_neg == a_neg);
		// vertex y: (|d|*2^(F+1) + |4a|) / |8a|, sign from -d*sgn(a)
		side_c.vy_num = (DIV_W'(d_abs) << (FRAC_BITS + 1)) + (DIV_W'(a_abs) << 2);
		side_c.vy_neg = (d_s2 != '0) && (d_neg == a_neg);
	end

	logic          v_s3;
	side_t         side_s3;
	logic [EW-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_c;
			rad_s3  <= rad_c;
		end
	end

	// ---- square root: two radicand bits, one root bit per stage ----
	logic [REM_W-1:0] sq_rem_s  [RW];
	logic [RW-1:0]    sq_root_s [RW];
	logic [EW-1:0]    sq_rad_s  [RW-1];
	side_t            sq_side_s [RW];
	logic             sq_v_s    [RW];

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [REM_W-1:0] rem_in, rem_sh, trial;
		logic [RW-1:0]    root_in;
		logic [EW-1:0]    rad_in;
		side_t            side_in;
		logic             v_in;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s3;
			assign side_in = side_s3;
			assign v_in    = v_s3;
		end else begin : g_next
			assign rem_in  = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign rad_in  = sq_rad_s[j-1];
			assign side_in = sq_side_s[j-1];
			assign v_in    = sq_v_s[j-1];
		end

		assign rem_sh = {rem_in[REM_W-3:0], rad_in[EW-1:EW-2]};
		assign trial  = REM_W'({root_in, 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j] <= 1'b0;
			end else if (adv) begin
				sq_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[j]  <= ge ? rem_sh - trial : rem_sh;
				sq_root_s[j] <= {root_in[RW-2:0], ge};
				sq_side_s[j] <= side_in;
			end
		end

		if (j < RW - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_rad_s[j] <= rad_in << 2;
				end
			end
		end
	end

	// ---- S4: floor(X +/- sqrt) for both roots ----
	side_t                sq_side;
	logic                 sq_inexact;
	logic signed [SW-1:0] x_w, r_w, sum_p, sum_m;

	assign sq_side    = sq_side_s[RW-1];
	assign sq_inexact = sq_rem_s[RW-1] != '0;
	assign x_w        = SW'($signed(sq_side.x));
	assign r_w        = SW'(sq_root_s[RW-1]);
	assign sum_p      = x_w + r_w;
	assign sum_m      = x_w - r_w - SW'(sq_inexact);

	logic                 v_s4;
	side_t                side_s4;
	logic signed [SW-1:0] f1_s4, f2_s4;
	logic                 inexact_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v_s[RW-1];
		end
	end

	// sign of a flips which root takes the plus
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4    <= sq_side;
			f1_s4      <= sq_side.a_neg ? sum_m : sum_p;
			f2_s4      <= sq_side.a_neg ? sum_p : sum_m;
			inexact_s4 <= sq_inexact;
		end
	end

	// ---- S5: magnitude plus half divisor, divider operands ----
	logic                 n1, n2;
	logic signed [SW-1:0] m1, m2;
	logic [DIV_W-1:0]     q_half;

	assign n1     = f1_s4[SW-1];
	assign n2     = f2_s4[SW-1];
	// floor(-T) = -floor(T) - 1 when T is not an integer
	assign m1     = n1 ? -f1_s4 - SW'(inexact_s4) : f1_s4;
	assign m2     = n2 ? -f2_s4 - SW'(inexact_s4) : f2_s4;
	assign q_half = DIV_W'(side_s4.a_abs) << 1;

	logic             v_s5;
	dside_t           dside_s5;
	logic [DIV_W-1:0] r1_num_s5, r2_num_s5, vx_num_s5, vy_num_s5;
	logic [DEN_W-1:0] den4_s5, den8_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s5.status <= side_s4.status;
			dside_s5.r1_neg <= n1;
			dside_s5.r2_neg <= n2;
			dside_s5.vx_neg <= side_s4.vx_neg;
			dside_s5.vy_neg <= side_s4.vy_neg;
			r1_num_s5       <= m1[DIV_W-1:0] + q_half;
			r2_num_s5       <= m2[DIV_W-1:0] + q_half;
			vx_num_s5       <= side_s4.vx_num;
			vy_num_s5       <= side_s4.vy_num;
			den4_s5         <= DEN_W'(side_s4.a_abs) << 2;
			den8_s5         <= DEN_W'(side_s4.a_abs) << 3;
		end
	end

	// ---- dividers ----
	logic [DIV_W-1:0] r1_quo, r2_quo, vx_quo, vy_quo;

	qrs_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div_r1 (
		.clk(clk), .en(adv), .num(r1_num_s5), .den(den4_s5), .quo(r1_quo)
	);
	qrs_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div_r2 (
		.clk(clk), .en(adv), .num(r2_num_s5), .den(den4_s5), .quo(r2_quo)
	);
	qrs_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div_vx (
		.clk(clk), .en(adv), .num(vx_num_s5), .den(den4_s5), .quo(vx_quo)
	);
	qrs_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div_vy (
		.clk(clk), .en(adv), .num(vy_num_s5), .den(den8_s5), .quo(vy_quo)
	);

	// status and signs ride alongside the divider stages
	dside_t dl_side_s [DIV_W];
	logic   dl_v_s    [DIV_W];

	for (genvar k = 0; k < DIV_W; k++) begin : g_dly
		dside_t side_in;
		logic   v_in;

		if (k == 0) begin : g_first
			assign side_in = dside_s5;
			assign v_in    = v_s5;
		end else begin : g_next
			assign side_in = dl_side_s[k-1];
			assign v_in    = dl_v_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dl_v_s[k] <= 1'b0;
			end else if (adv) begin
				dl_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dl_side_s[k] <= side_in;
			end
		end
	end

	// ---- output register ----
	dside_t           dl_side;
	logic [SW-1:0]    r1_sv, r2_sv, vx_sv, vy_sv;
	logic             roots_ok, vert_ok;
	logic [ROOT_W-1:0] r1_q, r2_q, vx_q;
	logic [VY_W-1:0]   vy_q;
	qrs_status_t       status_q;

	assign dl_side  = dl_side_s[DIV_W-1];
	assign r1_sv    = dl_side.r1_neg ? -SW'(r1_quo) : SW'(r1_quo);
	assign r2_sv    = dl_side.r2_neg ? -SW'(r2_quo) : SW'(r2_quo);
	assign vx_sv    = dl_side.vx_neg ? -SW'(vx_quo) : SW'(vx_quo);
	assign vy_sv    = dl_side.vy_neg ? -SW'(vy_quo) : SW'(vy_quo);
	assign roots_ok = (dl_side.status == ST_TWO_ROOTS) || (dl_side.status == ST_DOUBLE_ROOT);
	assign vert_ok  = dl_side.status != ST_NOT_QUAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= dl_v_s[DIV_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= dl_side.status;
			r1_q     <= roots_ok ? r1_sv[ROOT_W-1:0] : '0;
			r2_q     <= roots_ok ? r2_sv[ROOT_W-1:0] : '0;
			vx_q     <= vert_ok ? vx_sv[ROOT_W-1:0] : '0;
			vy_q     <= vert_ok ? vy_sv[VY_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = OUT_W'({vy_q, vx_q, r2_q, r1_q});

endmodule

FILE: sv/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
module qrs_div
	import qrs_pkg::*;
#(
	parameter int NUM_W = 52,
	parameter int DEN_W = 19
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s  [NUM_W-1];
	logic [DEN_W-1:0] den_s  [NUM_W-1];
	logic [NUM_W-1:0] work_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [NUM_W-1:0] work_in;
		logic [DEN_W:0]   trial;
		logic             take;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign den_in  = den;
			assign work_in = num;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign work_in = work_s[i-1];
		end

		// bring down the next dividend bit, subtract if it fits
		assign trial = {rem_in, work_in[NUM_W-1]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[i] <= {work_in[NUM_W-2:0], take};
			end
		end

		if (i < NUM_W - 1) begin : g_rem
			logic [DEN_W:0] diff;
			assign diff = trial - {1'b0, den_in};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign quo = work_s[NUM_W-1];

endmodule
